>>> hw/rtl/rdbm_pkg.sv
`timescale 1ns / 1ps

package rdbm_pkg;

  // Default size of each region, as a power of two in bytes.
  localparam int REGION_OFFSET_BITS = 20;

  // Region select codes, taken from address bits 31..20.
  localparam logic [11:0] SEL_PROGRAM = 12'h004;
  localparam logic [11:0] SEL_DATA    = 12'h100;
  localparam logic [11:0] SEL_STACK   = 12'h7ff;

  // Bank row groups, one per region.
  localparam logic [1:0] REGION_PROGRAM = 2'd0;
  localparam logic [1:0] REGION_DATA    = 2'd1;
  localparam logic [1:0] REGION_STACK   = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

endpackage

>>> hw/rtl/rdbm_req_if.sv
`timescale 1ns / 1ps

interface rdbm_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  size;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, output mode, output size, output address,
                  output write_data, input ready);
  modport sink (input valid, input mode, input size, input address,
                input write_data, output ready);
endinterface

>>> hw/rtl/rdbm_rsp_if.sv
`timescale 1ns / 1ps

interface rdbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink (input valid, input read_data, input status, output ready);
endinterface

>>> hw/rtl/rdbm_ram.sv
`timescale 1ns / 1ps

module rdbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/region_decoded_byte_memory.sv
`timescale 1ns / 1ps

// Little-endian load/store unit over three byte regions: program, data and
// stack, selected by address bits 31..20. The req channel carries one access
// per transfer (mode, size, address, write_data); the rsp channel returns one
// result per access (read_data, status), in order.
// Each region is spread over four byte-wide banks, one per byte lane, so an
// unaligned half word or word touches every lane at most once and finishes
// in a single bank access. A write commits at the edge of its request
// transfer; a read issues at that edge and its data lands in the bank output
// register, so the response is valid in the cycle after the request
// transfer. One access is accepted per cycle unless the receiver stalls; the
// bank port, shared by read and write, is the resource that sets that rate.
// When the receiver stalls, the pending result holds (bank outputs are only
// reloaded by a new read) and req.ready stays low until the result
// transfers. Reset clears only the pending-result flag; memory contents are
// undefined until written. Failed accesses (unmapped region, invalid size,
// past the region end) return status with zero data and touch no bank.
module region_decoded_byte_memory #(
  parameter int REGION_OFFSET_BITS = rdbm_pkg::REGION_OFFSET_BITS
) (
  input logic        clk,
  input logic        rst,
  rdbm_req_if.sink   req,
  rdbm_rsp_if.source rsp
);

  localparam int WORD_BITS  = REGION_OFFSET_BITS - 2;
  localparam int BANK_DEPTH = 3 << WORD_BITS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Request decode.
  logic [11:0]            sel;
  logic [19:0]            offset;
  logic [1:0]             region;
  logic                   region_hit;
  logic [2:0]             nbytes;
  logic [20:0]            end_sum;
  rdbm_pkg::status_t      status;
  logic                   accept;
  logic                   do_access;
  logic [WORD_BITS-1:0]   word_base;
  logic [1:0]             lane_off;

  // Per-lane bank controls.
  logic [1:0]             byte_idx  [4];
  logic                   lane_en   [4];
  logic                   bank_we   [4];
  logic                   bank_re   [4];
  logic [BANK_AW-1:0]     bank_addr [4];
  logic [7:0]             bank_wdata[4];
  logic [7:0]             bank_q    [4];

  // Pending result, waiting on bank output registers.
  logic                   s1_valid;
  rdbm_pkg::status_t      s1_status;
  logic                   s1_mode;
  logic [1:0]             s1_lane_off;
  logic [2:0]             s1_nbytes;
  logic [31:0]            s1_wdata;
  logic [31:0]            read_word;

  always_comb begin
    sel    = req.address[31:20];
    offset = req.address[19:0];
    region = rdbm_pkg::REGION_PROGRAM;
    region_hit = 1'b1;
    case (sel)
      rdbm_pkg::SEL_PROGRAM: region = rdbm_pkg::REGION_PROGRAM;
      rdbm_pkg::SEL_DATA:    region = rdbm_pkg::REGION_DATA;
      rdbm_pkg::SEL_STACK:   region = rdbm_pkg::REGION_STACK;
      default:               region_hit = 1'b0;
    endcase
    case (req.size)
      rdbm_pkg::SIZE_BYTE: nbytes = 3'd1;
      rdbm_pkg::SIZE_HALF: nbytes = 3'd2;
      rdbm_pkg::SIZE_WORD: nbytes = 3'd4;
      default:             nbytes = 3'd0;
    endcase
    // The end check also catches offset bits above the region size.
    end_sum = {1'b0, offset} + {18'd0, nbytes};
    if (!region_hit) begin
      status = rdbm_pkg::ST_UNMAPPED;
    end else if (nbytes == 3'd0) begin
      status = rdbm_pkg::ST_BAD_SIZE;
    end else if (end_sum > (21'd1 << REGION_OFFSET_BITS)) begin
      status = rdbm_pkg::ST_PAST_END;
    end else begin
      status = rdbm_pkg::ST_OK;
    end
  end

  assign req.ready = !s1_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign do_access = accept && (status == rdbm_pkg::ST_OK);
  assign word_base = offset[REGION_OFFSET_BITS-1:2];
  assign lane_off  = offset[1:0];

  // Lanes below the starting lane hold the bytes that spill into the next
  // word; the range check guarantees that word stays inside the region.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      byte_idx[l]   = 2'(l) - lane_off;
      lane_en[l]    = {1'b0, byte_idx[l]} < nbytes;
      bank_we[l]    = do_access && (req.mode == rdbm_pkg::MODE_WRITE) && lane_en[l];
      bank_re[l]    = do_access && (req.mode == rdbm_pkg::MODE_READ);
      bank_addr[l]  = {region,
                       word_base + WORD_BITS'(2'(l) < lane_off)};
      bank_wdata[l] = 8'(req.write_data >> {byte_idx[l], 3'b000});
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rdbm_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .re    (bank_re[g]),
      .addr  (bank_addr[g]),
      .wdata (bank_wdata[g]),
      .rdata (bank_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (accept) begin
      s1_status   <= status;
      s1_mode     <= req.mode;
      s1_lane_off <= lane_off;
      s1_nbytes   <= nbytes;
      s1_wdata    <= req.write_data;
    end
  end

  // Rotate the bank outputs back into byte order and zero the unused bytes.
  always_comb begin
    logic [1:0] lane;
    read_word = 32'd0;
    for (int i = 0; i < 4; i++) begin
      lane = 2'(i) + s1_lane_off;
      if (3'(i) < s1_nbytes) begin
        read_word[8*i +: 8] = bank_q[lane];
      end
    end
  end

  assign rsp.valid     = s1_valid;
  assign rsp.status    = s1_status;
  assign rsp.read_data = (s1_status != rdbm_pkg::ST_OK) ? 32'd0 :
                         (s1_mode == rdbm_pkg::MODE_WRITE) ? s1_wdata : read_word;

endmodule
